// ----- hw/rtl/quadtree_minmax_reduce_macros.svh -----
// Assertion macros for the quadtree min/max reduction checker.
// Used by qmr_checker.sv; no other dependencies.
`ifndef QUADTREE_MINMAX_REDUCE_MACROS_SVH
`define QUADTREE_MINMAX_REDUCE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define QMR_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define QMR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/qmr_pkg.sv -----
// Package for the quadtree min/max reduction: constants, register codes,
// accumulator entry type. No dependencies.
`default_nettype none

package qmr_pkg;

    localparam int MAX_PARENT_WIDTH = 1024;

    localparam int COORD_W  = 24;
    localparam int PCOORD_W = 23;
    localparam int HEIGHT_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 112;

    typedef enum logic [2:0] {
        REG_LOW_X    = 3'd0,
        REG_LOW_Y    = 3'd1,
        REG_HIGH_X   = 3'd2,
        REG_HIGH_Y   = 3'd3,
        REG_FORCE_WT = 3'd4
    } reg_idx_t;

    // One accumulator entry: partial parent under construction.
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] max_h;
        logic signed [HEIGHT_W-1:0] min_h;
        logic                       allwt;
        logic                       ex;
    } acc_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/quadtree_minmax_reduce.sv -----
// Top level of the quadtree min/max reduction: one pyramid level, 2x2 parents.
// Depends on qmr_pkg.
//
// Output path: after the edge that accepts its last child, a parent word reaches m_
//   through one stage for the accumulator read, then the output register.
// Throughput: one child word per cycle unless m_ stalls, set by one read-modify-write of the
//   half-row accumulator memory per child (write data forwarded to the next read).
// Reset: synchronous, active low; range registers and position go to zero,
//   accumulator memory contents stay undefined (never read before written).
`default_nettype none

module quadtree_minmax_reduce #(
    parameter int MAX_PARENT_WIDTH = qmr_pkg::MAX_PARENT_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // child words
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // [0] child_exists, [1] child_watertight, [33:2] child_min_height,
    // [65:34] child_max_height, [71:66] zero
    input  wire logic [qmr_pkg::S_TDATA_W-1:0]    s_tdata,
    // parent words
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [22:0] parent_x, [45:23] parent_y, [46] parent_exists,
    // [47] parent_watertight, [79:48] parent_min_height, [111:80] parent_max_height
    output      logic [qmr_pkg::M_TDATA_W-1:0]    m_tdata,
    output      logic                             m_tlast,   // last_parent
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [qmr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [qmr_pkg::CFG_DATA_W-1:0]   pwdata,
    output      logic [qmr_pkg::CFG_DATA_W-1:0]   prdata,
    output      logic                             pready
);

    localparam int CW    = qmr_pkg::COORD_W;
    localparam int PW    = qmr_pkg::PCOORD_W;
    localparam int HW    = qmr_pkg::HEIGHT_W;
    localparam int IDX_W = (MAX_PARENT_WIDTH > 1) ? $clog2(MAX_PARENT_WIDTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARENT_WIDTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] low_x_reg, low_y_reg, high_x_reg, high_y_reg;
    logic          force_wt_reg;
    logic          cfg_we;
    logic          cfg_restart;
    qmr_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = qmr_pkg::reg_idx_t'(paddr[4:2]);

    // any range register write restarts the pass
    always_comb begin
        case (cfg_idx)
            qmr_pkg::REG_LOW_X, qmr_pkg::REG_LOW_Y,
            qmr_pkg::REG_HIGH_X, qmr_pkg::REG_HIGH_Y: cfg_restart = cfg_we;
            default:                                  cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg    <= '0;
            low_y_reg    <= '0;
            high_x_reg   <= '0;
            high_y_reg   <= '0;
            force_wt_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                qmr_pkg::REG_LOW_X:    low_x_reg    <= pwdata[CW-1:0];
                qmr_pkg::REG_LOW_Y:    low_y_reg    <= pwdata[CW-1:0];
                qmr_pkg::REG_HIGH_X:   high_x_reg   <= pwdata[CW-1:0];
                qmr_pkg::REG_HIGH_Y:   high_y_reg   <= pwdata[CW-1:0];
                qmr_pkg::REG_FORCE_WT: force_wt_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            qmr_pkg::REG_LOW_X:    prdata = {8'd0, low_x_reg};
            qmr_pkg::REG_LOW_Y:    prdata = {8'd0, low_y_reg};
            qmr_pkg::REG_HIGH_X:   prdata = {8'd0, high_x_reg};
            qmr_pkg::REG_HIGH_Y:   prdata = {8'd0, high_y_reg};
            qmr_pkg::REG_FORCE_WT: prdata = {31'd0, force_wt_reg};
            default:               prdata = '0;
        endcase
    end

    // inverted range collapses to one column / one row
    logic [CW-1:0] hx, hy;
    assign hx = (high_x_reg < low_x_reg) ? low_x_reg : high_x_reg;
    assign hy = (high_y_reg < low_y_reg) ? low_y_reg : high_y_reg;

    // ------------------------------------------------------------------
    // Stage 0: position tracking, accumulator read
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next, row_reg, row_next;
    logic [IDX_W-1:0] idx_reg, idx_next;   // (px - low_x/2) mod depth, kept incrementally
    logic             s_accept;
    logic             col_end, row_end;
    logic             c_first, c_last, c_full, c_lastp;

    assign s_accept = s_tvalid & s_tready;
    assign col_end  = (col_reg == hx);
    assign row_end  = (row_reg == hy);

    assign c_first = ((col_reg == low_x_reg) || !col_reg[0])
                   && ((row_reg == low_y_reg) || !row_reg[0]);
    assign c_last  = (col_end || col_reg[0]) && (row_end || row_reg[0]);
    assign c_lastp = col_end & row_end;
    // all four children inside the rectangle
    assign c_full  = ({col_reg[CW-1:1], 1'b0} >= low_x_reg)
                   && ({col_reg[CW-1:1], 1'b1} <= hx)
                   && ({row_reg[CW-1:1], 1'b0} >= low_y_reg)
                   && ({row_reg[CW-1:1], 1'b1} <= hy);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        idx_next = idx_reg;
        if (cfg_restart) begin
            col_next = (cfg_idx == qmr_pkg::REG_LOW_X) ? pwdata[CW-1:0] : low_x_reg;
            row_next = (cfg_idx == qmr_pkg::REG_LOW_Y) ? pwdata[CW-1:0] : low_y_reg;
            idx_next = '0;
        end else if (s_accept) begin
            if (col_end) begin
                col_next = low_x_reg;
                row_next = row_end ? low_y_reg : row_reg + CW'(1);
                idx_next = '0;
            end else begin
                col_next = col_reg + CW'(1);
                // moving onto an even column starts the next parent
                if (col_reg[0]) begin
                    idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            idx_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            idx_reg <= idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator memory: read at accept, write when stage 1 retires
    // ------------------------------------------------------------------
    qmr_pkg::acc_entry_t acc_mem [MAX_PARENT_WIDTH];
    qmr_pkg::acc_entry_t rd_data_reg;
    qmr_pkg::acc_entry_t acc_upd;
    logic                acc_we;
    logic [IDX_W-1:0]    s1_idx_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= acc_mem[idx_reg];
        end
        if (acc_we) begin
            acc_mem[s1_idx_reg] <= acc_upd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: merge child into parent entry
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic                 s1_first_reg, s1_last_reg, s1_full_reg, s1_lastp_reg;
    logic [PW-1:0]        s1_px_reg, s1_py_reg;
    logic                 s1_ce_reg, s1_cw_reg;
    logic signed [HW-1:0] s1_cmin_reg, s1_cmax_reg;
    logic                 s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg   <= idx_reg;
            s1_first_reg <= c_first;
            s1_last_reg  <= c_last;
            s1_full_reg  <= c_full;
            s1_lastp_reg <= c_lastp;
            s1_px_reg    <= col_reg[CW-1:1];
            s1_py_reg    <= row_reg[CW-1:1];
            s1_ce_reg    <= s_tdata[0];
            s1_cw_reg    <= s_tdata[1];
            s1_cmin_reg  <= s_tdata[33:2];
            s1_cmax_reg  <= s_tdata[65:34];
        end
    end

    // last write, forwarded when the read raced it
    logic                wr_valid_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    qmr_pkg::acc_entry_t wr_data_reg;
    qmr_pkg::acc_entry_t acc_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else if (acc_we) begin
            wr_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            wr_idx_reg  <= s1_idx_reg;
            wr_data_reg <= acc_upd;
        end
    end

    always_comb begin
        if (s1_first_reg) begin
            acc_base       = '0;
            acc_base.allwt = 1'b1;
        end else if (wr_valid_reg && (wr_idx_reg == s1_idx_reg)) begin
            acc_base = wr_data_reg;
        end else begin
            acc_base = rd_data_reg;
        end

        acc_upd       = acc_base;
        acc_upd.allwt = acc_base.allwt & s1_ce_reg & s1_cw_reg;
        if (s1_ce_reg) begin
            if (acc_base.ex) begin
                if (s1_cmin_reg < acc_base.min_h) acc_upd.min_h = s1_cmin_reg;
                if (s1_cmax_reg > acc_base.max_h) acc_upd.max_h = s1_cmax_reg;
            end else begin
                acc_upd.min_h = s1_cmin_reg;
                acc_upd.max_h = s1_cmax_reg;
            end
            acc_upd.ex = 1'b1;
        end
    end

    logic m_valid_reg;

    // a child that closes no parent always retires; one that does needs the output slot
    assign s1_adv   = s1_valid_reg & (~s1_last_reg | ~m_valid_reg | m_tready);
    assign acc_we   = s1_adv;
    assign s_tready = ~s1_valid_reg | s1_adv;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [qmr_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_last_reg;
    logic                          p_wt;

    assign p_wt = acc_upd.ex & (force_wt_reg | (s1_full_reg & acc_upd.allwt));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_last_reg) begin
            m_data_reg <= {acc_upd.ex ? acc_upd.max_h : HW'(0),
                           acc_upd.ex ? acc_upd.min_h : HW'(0),
                           p_wt, acc_upd.ex, s1_py_reg, s1_px_reg};
            m_last_reg <= s1_lastp_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qmr_checker.sv -----
// Port-level checker for quadtree_minmax_reduce, bound to the top level.
// Depends on qmr_pkg and quadtree_minmax_reduce_macros.svh.
`default_nettype none

`include "quadtree_minmax_reduce_macros.svh"

module qmr_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [qmr_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tlast
);

    // stalled parent word holds
    `QMR_ASSERT_NEXT(a_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "parent word changed under stall")

    // absent parent carries zero heights and no watertight flag
    `QMR_ASSERT_NOW(a_absent, aclk, !aresetn, m_tvalid && !m_tdata[46], m_tdata[111:47] == '0, "absent parent not zeroed")

    // a parent can only be watertight if it exists
    `QMR_ASSERT_NOW(a_wt_ex, aclk, !aresetn, m_tvalid && m_tdata[47], m_tdata[46], "watertight parent without data")

    // reset empties the output
    `QMR_ASSERT_NEXT(a_reset, aclk, 1'b0, !aresetn, !m_tvalid, "parent word valid after reset")

endmodule

bind quadtree_minmax_reduce qmr_checker u_qmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
